[src/lse_pkg.sv]
package lse_pkg;

    localparam int HEADER_BYTES = 54;
    localparam int MAGIC_MAX    = 8;
    localparam int COUNT_W      = 35;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ADDR_W   = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_MAGIC_VALUE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAGIC_LENGTH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SECRET_SIZE  = 2'd2;

    typedef struct packed {
        logic [63:0] magic_value;
        logic [3:0]  magic_length;
        logic [31:0] secret_size;
    } cfg_t;

    typedef struct packed {
        logic       image_start;
        logic [7:0] secret_byte;
        logic [7:0] image_byte;
    } item_t;

    typedef struct packed {
        logic embedding_done;
        logic capacity_short;
        logic secret_used;
    } flags_t;

    function automatic logic [7:0] ext_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = 8'h2E;
            2'd1:    c = 8'h74;
            2'd2:    c = 8'h78;
            default: c = 8'h74;
        endcase
        return c;
    endfunction

endpackage

[src/lse_front.sv]
module lse_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lse_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output lse_pkg::item_t  head_item
);
    import lse_pkg::*;

    item_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  fill_reg;
    logic [QCNT_W-1:0]  fill_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[src/lse_back.sv]
module lse_back (
    input  logic            clk,
    input  logic            rst_n,
    input  lse_pkg::cfg_t   cfg,
    input  logic            head_valid,
    input  lse_pkg::item_t  head_item,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output lse_pkg::flags_t out_flags
);
    import lse_pkg::*;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_MAGIC  = 3'd1;
    localparam logic [2:0] PH_EXTLEN = 3'd2;
    localparam logic [2:0] PH_EXT    = 3'd3;
    localparam logic [2:0] PH_SIZE   = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;
    localparam logic [2:0] PH_SHORT  = 3'd7;

    localparam int NEED_W = 37;

    logic [2:0]         phase_reg;
    logic [2:0]         phase_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [31:0]        width_reg;
    logic [31:0]        width_next;
    logic [31:0]        height_reg;
    logic [31:0]        height_next;
    logic [7:0]         shift_reg;
    logic [7:0]         shift_next;
    logic [31:0]        prod_reg;
    logic [31:0]        cap_reg;
    logic [1:0]         wait_reg;
    logic [1:0]         wait_next;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    flags_t             out_flags_reg;

    logic               start;
    logic [2:0]         ph0;
    logic [COUNT_W-1:0] n0;
    logic [31:0]        w0;
    logic [31:0]        h0;
    logic [7:0]         sh0;
    logic [3:0]         mcount;
    logic [32:0]        field_sum;
    logic [NEED_W-1:0]  need;
    logic               cap_ok;
    logic               decide;
    logic               stall;
    logic               out_free;
    logic [2:0]         p1;
    logic [COUNT_W-1:0] n1;
    logic               adv1;
    logic [2:0]         p2;
    logic [COUNT_W-1:0] n2;
    logic               captured;
    logic               embed;
    logic               bit_val;
    logic               used;
    logic [7:0]         magic_c;
    logic [7:0]         ext_c;
    logic [7:0]         byte_out;

    function automatic logic [COUNT_W-1:0] phase_bits(
        input logic [2:0]  p,
        input logic [3:0]  mc,
        input logic [31:0] sz
    );
        logic [COUNT_W-1:0] r;
        unique case (p)
            PH_MAGIC:  r = {{(COUNT_W - 7){1'b0}}, mc, 3'b000};
            PH_EXTLEN: r = COUNT_W'(32);
            PH_EXT:    r = COUNT_W'(32);
            PH_SIZE:   r = COUNT_W'(32);
            PH_DATA:   r = {sz, 3'b000};
            default:   r = '0;
        endcase
        return r;
    endfunction

    assign start    = head_item.image_start;
    assign ph0      = start ? PH_HEADER : phase_reg;
    assign n0       = start ? '0 : count_reg;
    assign w0       = start ? '0 : width_reg;
    assign h0       = start ? '0 : height_reg;
    assign sh0      = start ? '0 : shift_reg;

    assign mcount    = (cfg.magic_length > 4'(MAGIC_MAX)) ? 4'(MAGIC_MAX) : cfg.magic_length;
    assign field_sum = {29'd0, mcount} + 33'd12 + {1'b0, cfg.secret_size};
    assign need      = NEED_W'(HEADER_BYTES) + {1'b0, field_sum, 3'b000};
    assign cap_ok    = {{(NEED_W - 32){1'b0}}, cap_reg} > need;

    assign decide   = (ph0 == PH_HEADER) && (n0 >= COUNT_W'(HEADER_BYTES));
    assign stall    = decide && (wait_reg != '0);
    assign out_free = !out_valid_reg || out_ready;
    assign pop      = head_valid && out_free && !stall;

    always_comb
    begin
        p1   = ph0;
        n1   = n0;
        adv1 = 1'b0;
        if (decide)
        begin
            p1   = cap_ok ? PH_MAGIC : PH_SHORT;
            n1   = '0;
            adv1 = 1'b1;
        end
        else if ((ph0 >= PH_MAGIC) && (ph0 <= PH_DATA)
                 && (n0 >= phase_bits(ph0, mcount, cfg.secret_size)))
        begin
            p1   = ph0 + 3'd1;
            n1   = '0;
            adv1 = 1'b1;
        end
        p2 = p1;
        n2 = n1;
        if (adv1 && (p1 >= PH_MAGIC) && (p1 <= PH_DATA)
            && (phase_bits(p1, mcount, cfg.secret_size) == '0))
        begin
            p2 = p1 + 3'd1;
        end
    end

    assign magic_c = cfg.magic_value[{n2[5:3], 3'b000} +: 8];
    assign ext_c   = ext_char(n2[4:3]);

    always_comb
    begin
        width_next  = w0;
        height_next = h0;
        shift_next  = sh0;
        captured    = 1'b0;
        embed       = 1'b0;
        bit_val     = 1'b0;
        used        = 1'b0;
        unique case (p2)
            PH_HEADER:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    if (n2 == COUNT_W'(18 + k))
                    begin
                        width_next[8*k +: 8] = head_item.image_byte;
                        captured             = 1'b1;
                    end
                    if (n2 == COUNT_W'(22 + k))
                    begin
                        height_next[8*k +: 8] = head_item.image_byte;
                        captured              = 1'b1;
                    end
                end
            end
            PH_MAGIC:
            begin
                bit_val = magic_c[3'd7 - n2[2:0]];
                embed   = 1'b1;
            end
            PH_EXTLEN:
            begin
                bit_val = (n2[4:0] == 5'd29);
                embed   = 1'b1;
            end
            PH_EXT:
            begin
                bit_val = ext_c[3'd7 - n2[2:0]];
                embed   = 1'b1;
            end
            PH_SIZE:
            begin
                bit_val = cfg.secret_size[5'd31 - n2[4:0]];
                embed   = 1'b1;
            end
            PH_DATA:
            begin
                if (n2[2:0] == 3'd0)
                begin
                    bit_val    = head_item.secret_byte[7];
                    shift_next = {head_item.secret_byte[6:0], 1'b0};
                    used       = 1'b1;
                end
                else
                begin
                    bit_val    = sh0[7];
                    shift_next = {sh0[6:0], 1'b0};
                end
                embed = 1'b1;
            end
            default:
            begin
                embed = 1'b0;
            end
        endcase
        phase_next = p2;
        count_next = (p2 <= PH_DATA) ? n2 + 1'b1 : n2;
        byte_out   = embed ? {head_item.image_byte[7:1], bit_val} : head_item.image_byte;
        if (pop && (start || captured))
        begin
            wait_next = 2'd2;
        end
        else
        begin
            wait_next = (wait_reg != '0) ? wait_reg - 1'b1 : wait_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            count_reg     <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            shift_reg     <= '0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wait_reg <= wait_next;
            if (pop)
            begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                width_reg  <= width_next;
                height_reg <= height_next;
                shift_reg  <= shift_next;
            end
            if (out_free)
            begin
                out_valid_reg <= pop;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= width_reg * height_reg;
        cap_reg  <= prod_reg + {prod_reg[30:0], 1'b0};
        if (pop)
        begin
            out_byte_reg                 <= byte_out;
            out_flags_reg.secret_used    <= used;
            out_flags_reg.capacity_short <= (p2 == PH_SHORT);
            out_flags_reg.embedding_done <= (p2 == PH_DONE);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_flags = out_flags_reg;

endmodule

[src/lsb_stego_embedder.sv]
// Each input passes the input queue, then the output register, to the master side.
// Throughput: one byte per cycle unless the master side stalls; the first byte after
// the header waits while a just captured width or height is in the product pipeline.
// Reset (rst_n low, asynchronous): queue emptied, framing back to header phase,
// captures cleared, registers to magic_length 2, magic_value 0, secret_size 0.
module lsb_stego_embedder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,  // image_byte, secret_byte
    input  logic                           s_axis_tuser,  // image_start
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,  // out_byte
    output logic [2:0]                     m_axis_tuser,  // secret_used, capacity_short,
                                                          // embedding_done
    input  logic                           cfg_we,
    input  logic [lse_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lse_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import lse_pkg::*;

    cfg_t   cfg_reg;
    item_t  in_item;
    item_t  head_item;
    logic   queue_full;
    logic   head_valid;
    logic   pop;
    flags_t out_flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_value  <= '0;
            cfg_reg.magic_length <= 4'd2;
            cfg_reg.secret_size  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MAGIC_VALUE:  cfg_reg.magic_value  <= cfg_wdata;
                REG_MAGIC_LENGTH: cfg_reg.magic_length <= cfg_wdata[3:0];
                REG_SECRET_SIZE:  cfg_reg.secret_size  <= cfg_wdata[31:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign in_item.image_byte  = s_axis_tdata[7:0];
    assign in_item.secret_byte = s_axis_tdata[15:8];
    assign in_item.image_start = s_axis_tuser;
    assign s_axis_tready       = !queue_full;

    lse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_axis_tvalid),
        .push_item  (in_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    lse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_flags  (out_flags)
    );

    assign m_axis_tuser = {out_flags.embedding_done, out_flags.capacity_short,
                           out_flags.secret_used};

endmodule

[src/lse_checker.sv]
module lse_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tready,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic [2:0] m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result transaction changed while stalled");

    a_short_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[1] && m_axis_tuser[2]))
        else $error("capacity_short and embedding_done both set");

    a_used_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1] && !m_axis_tuser[2])
        else $error("secret consumed outside data phase");

    a_quiet_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result transaction right after reset");

    a_handshake_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({s_axis_tready, m_axis_tvalid}))
        else $error("handshake signal unknown");

endmodule

bind lsb_stego_embedder lse_checker u_lse_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps

package stego_tb_pkg;

    localparam logic [31:0] EXT_LEN  = 32'd4;
    localparam logic [31:0] EXT_NAME = ".txt";

    class stego_scoreboard;

        typedef enum logic [2:0] {
            PH_HEADER, PH_MAGIC, PH_EXTLEN, PH_EXT, PH_SIZE, PH_DATA, PH_DONE, PH_SHORT
        } phase_e;

        typedef struct packed {
            logic [7:0]      out_byte;
            lse_pkg::flags_t flags;
        } stego_byte_t;

        logic [63:0]   magic_value;
        logic [3:0]    magic_length;
        logic [31:0]   secret_size;

        phase_e        phase;
        logic [34:0]   pos;
        logic [31:0]   width_cap;
        logic [31:0]   height_cap;
        logic [7:0]    secret_bits;

        stego_byte_t   stego_bytes_due[$];
        int            mismatches;
        int            checked;
        int            secret_bytes_taken;
        int            done_bytes;
        int            short_bytes;

        function new();
            magic_value        = '0;
            magic_length       = 4'd2;
            secret_size        = '0;
            phase              = PH_HEADER;
            pos                = '0;
            width_cap          = '0;
            height_cap         = '0;
            secret_bits        = '0;
            mismatches         = 0;
            checked            = 0;
            secret_bytes_taken = 0;
            done_bytes         = 0;
            short_bytes        = 0;
        endfunction

        function void write_reg(logic [lse_pkg::CFG_ADDR_W-1:0] addr,
                                logic [lse_pkg::CFG_DATA_W-1:0] data);
            case (addr)
                lse_pkg::REG_MAGIC_VALUE:  magic_value  = data;
                lse_pkg::REG_MAGIC_LENGTH: magic_length = data[3:0];
                lse_pkg::REG_SECRET_SIZE:  secret_size  = data[31:0];
                default: ;
            endcase
        endfunction

        function logic [3:0] magic_chars();
            return (magic_length > 4'(lse_pkg::MAGIC_MAX)) ? 4'(lse_pkg::MAGIC_MAX)
                                                           : magic_length;
        endfunction

        function logic [34:0] field_bits(phase_e p);
            case (p)
                PH_MAGIC:  return 35'(magic_chars()) << 3;
                PH_EXTLEN,
                PH_EXT,
                PH_SIZE:   return 35'd32;
                PH_DATA:   return 35'(secret_size) << 3;
                default:   return 35'd0;
            endcase
        endfunction

        function void advance_framing();
            logic [31:0] capacity;
            logic [63:0] needed;
            for (int g = 0; g < 8; g++)
            begin
                if (phase == PH_HEADER)
                begin
                    if (pos < 35'(lse_pkg::HEADER_BYTES))
                        return;
                    capacity = width_cap * height_cap * 32'd3;
                    needed   = 64'(lse_pkg::HEADER_BYTES) +
                               (64'(magic_chars()) + 64'd12 + 64'(secret_size)) * 64'd8;
                    phase    = (64'(capacity) > needed) ? PH_MAGIC : PH_SHORT;
                    pos      = '0;
                end
                else if (phase >= PH_MAGIC && phase <= PH_DATA)
                begin
                    if (pos < field_bits(phase))
                        return;
                    phase = phase_e'(phase + 3'd1);
                    pos   = '0;
                end
                else
                    return;
            end
        endfunction

        function void take_image_byte(logic [7:0] ib, logic [7:0] sbyte, logic start);
            stego_byte_t due;
            logic        lsb;
            logic        embed;
            logic        used;
            logic [7:0]  c;
            int          k;
            lsb   = 1'b0;
            embed = 1'b0;
            used  = 1'b0;
            if (start)
            begin
                phase       = PH_HEADER;
                pos         = '0;
                width_cap   = '0;
                height_cap  = '0;
                secret_bits = '0;
            end
            advance_framing();
            k = int'(pos[4:0]);
            case (phase)
                PH_HEADER:
                begin
                    if (pos >= 35'd18 && pos < 35'd22)
                        width_cap[(k - 18) * 8 +: 8] = ib;
                    else if (pos >= 35'd22 && pos < 35'd26)
                        height_cap[(k - 22) * 8 +: 8] = ib;
                end
                PH_MAGIC:
                begin
                    c     = magic_value[int'(pos[5:3]) * 8 +: 8];
                    lsb   = c[7 - int'(pos[2:0])];
                    embed = 1'b1;
                end
                PH_EXTLEN:
                begin
                    lsb   = EXT_LEN[31 - k];
                    embed = 1'b1;
                end
                PH_EXT:
                begin
                    lsb   = EXT_NAME[31 - k];
                    embed = 1'b1;
                end
                PH_SIZE:
                begin
                    lsb   = secret_size[31 - k];
                    embed = 1'b1;
                end
                PH_DATA:
                begin
                    if (pos[2:0] == 3'd0)
                    begin
                        lsb         = sbyte[7];
                        secret_bits = {sbyte[6:0], 1'b0};
                        used        = 1'b1;
                    end
                    else
                    begin
                        lsb         = secret_bits[7];
                        secret_bits = {secret_bits[6:0], 1'b0};
                    end
                    embed = 1'b1;
                end
                default: ;
            endcase
            if (phase <= PH_DATA)
                pos = pos + 35'd1;

            due.out_byte             = embed ? {ib[7:1], lsb} : ib;
            due.flags.secret_used    = used;
            due.flags.capacity_short = (phase == PH_SHORT);
            due.flags.embedding_done = (phase == PH_DONE);
            stego_bytes_due.push_back(due);
            secret_bytes_taken += int'(used);
            done_bytes         += int'(phase == PH_DONE);
            short_bytes        += int'(phase == PH_SHORT);
        endfunction

        function void check_stego_byte(logic [7:0] got_byte, lse_pkg::flags_t got_flags);
            stego_byte_t due;
            if (stego_bytes_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: out_byte %02h flags %03b", got_byte, got_flags);
                return;
            end
            due = stego_bytes_due.pop_front();
            if (got_byte !== due.out_byte ||
                got_flags.secret_used !== due.flags.secret_used ||
                got_flags.capacity_short !== due.flags.capacity_short ||
                got_flags.embedding_done !== due.flags.embedding_done)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch at result %0d: out_byte exp %02h got %02h",
                             checked, due.out_byte, got_byte);
                    $display("  used exp %0b got %0b, short exp %0b got %0b, done exp %0b got %0b",
                             due.flags.secret_used, got_flags.secret_used,
                             due.flags.capacity_short, got_flags.capacity_short,
                             due.flags.embedding_done, got_flags.embedding_done);
                end
            end
            checked++;
        endfunction

        function int pending();
            return stego_bytes_due.size();
        endfunction

    endclass

endpackage

module tb_top;

    import lse_pkg::*;
    import stego_tb_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;   // image_byte, secret_byte
    logic                  s_axis_tuser;   // image_start
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;   // out_byte
    logic [2:0]            m_axis_tuser;   // secret_used, capacity_short, embedding_done
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    stego_scoreboard sb;
    bit              steady_in;
    bit              steady_out;
    int              bytes_sent;
    int              images;
    int              reg_writes;

    lsb_stego_embedder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.take_image_byte(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_stego_byte(m_axis_tdata, flags_t'(m_axis_tuser));
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial
    begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (steady_out)
                m_axis_tready <= 1'b1;
            else
            begin
                stall_left = pick_gap();
                m_axis_tready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    task automatic send_byte(input logic [7:0] ib, input logic [7:0] sbyte, input logic start);
        int gap;
        gap = steady_in ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sbyte, ib};
        s_axis_tuser  <= start;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic drain_block();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(addr, data);
        reg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [63:0] mv, input logic [3:0] ml,
                              input logic [31:0] ss);
        drain_block();
        write_reg(REG_MAGIC_VALUE, mv);
        write_reg(REG_MAGIC_LENGTH, 64'(ml));
        write_reg(REG_SECRET_SIZE, 64'(ss));
    endtask

    task automatic random_config();
        logic [63:0] mv;
        logic [3:0]  ml;
        logic [31:0] ss;
        int          r;
        r  = $urandom_range(0, 9);
        mv = (r == 0) ? 64'd0 : (r == 1) ? '1 : {$urandom, $urandom};
        ml = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15))
                                         : 4'($urandom_range(0, 8));
        ss = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 6));
        set_config(mv, ml, ss);
    endtask

    // bytes needed to finish embedding under the current registers, or HEADER_BYTES + 30 above 64 secret bytes
    function automatic int embed_len();
        logic [3:0] mc;
        mc = (sb.magic_length > 4'(MAGIC_MAX)) ? 4'(MAGIC_MAX) : sb.magic_length;
        if (sb.secret_size > 32'd64)
            return HEADER_BYTES + 30;
        return HEADER_BYTES + (int'(mc) + 12 + int'(sb.secret_size)) * 8;
    endfunction

    task automatic run_image(input logic [31:0] w, input logic [31:0] h, input int len,
                             input bit marked, input int cut_at, input int cut_size);
        logic [7:0] b;
        int         i;
        int         r;
        images++;
        for (i = 0; i < len; i++)
        begin
            if (i == cut_at)
            begin
                drain_block();
                r = $urandom_range(0, 2);
                if (cut_size >= 0)
                    write_reg(REG_SECRET_SIZE, 64'(cut_size));
                else if (r == 0)
                    write_reg(REG_MAGIC_VALUE, {$urandom, $urandom});
                else if (r == 1)
                    write_reg(REG_MAGIC_LENGTH, 64'($urandom_range(0, 15)));
                else
                    write_reg(REG_SECRET_SIZE, 64'($urandom_range(0, 3)));
            end
            if (i >= 18 && i < 22)
                b = w[(i - 18) * 8 +: 8];
            else if (i >= 22 && i < 26)
                b = h[(i - 22) * 8 +: 8];
            else
                b = 8'($urandom_range(0, 255));
            send_byte(b, 8'($urandom_range(0, 255)), marked && i == 0);
        end
    endtask

    initial
    begin
        logic [7:0]  corner_vals [8];
        logic [31:0] w;
        logic [31:0] h;
        int          kind;
        int          full;
        int          cut;
        int          guard;

        corner_vals   = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA};
        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        steady_in     = 1'b0;
        steady_out    = 1'b0;
        bytes_sent    = 0;
        images        = 0;
        reg_writes    = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // no start mark after reset, stream cut off inside the header
        for (int i = 0; i < 30; i++)
            send_byte(corner_vals[i % 8], corner_vals[(i + 3) % 8], 1'b0);

        // oversized magic length, all-ones magic, no secret bytes
        set_config('1, 4'd15, 32'd0);
        run_image(32'd100, 32'd1, embed_len() + 8, 1'b1, -1, -1);

        // no magic characters
        set_config(64'd0, 4'd0, 32'd3);
        steady_in  = 1'b1;
        steady_out = 1'b1;
        run_image(32'd20, 32'd20, embed_len() + 8, 1'b1, -1, -1);
        steady_in  = 1'b0;
        steady_out = 1'b0;

        // capacity exactly at the limit, then one step above it
        set_config({$urandom, $urandom}, 4'd0, 32'd0);
        run_image(32'd50, 32'd1, HEADER_BYTES + 12, 1'b1, -1, -1);
        set_config({$urandom, $urandom}, 4'd1, 32'd0);
        run_image(32'd53, 32'd1, embed_len() + 4, 1'b1, -1, -1);

        // capacity product wraps to zero
        run_image(32'h0001_0000, 32'h0001_0000, HEADER_BYTES + 6, 1'b1, -1, -1);

        // largest secret size never fits
        set_config({$urandom, $urandom}, 4'd8, 32'hFFFF_FFFF);
        run_image(32'hFFFF_FFFF, 32'd1, HEADER_BYTES + 6, 1'b1, -1, -1);

        // secret size drops below the bits already written
        set_config({$urandom, $urandom}, 4'd2, 32'd4);
        run_image(32'd40, 32'd40, embed_len() + 10, 1'b1,
                  HEADER_BYTES + (2 + 12) * 8 + 12, 1);

        while (bytes_sent < 1850)
        begin
            if ($urandom_range(0, 9) < 4)
                random_config();
            steady_in  = ($urandom_range(0, 4) == 0);
            steady_out = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 99);
            full = embed_len();
            w    = 32'($urandom_range(16, 255));
            h    = 32'($urandom_range(16, 255));
            if (kind < 60)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    w = 32'hFFFF_FFFF;
                    h = 32'd1;
                end
                cut = ($urandom_range(0, 6) == 0) ? $urandom_range(50, full - 1) : -1;
                run_image(w, h, full + $urandom_range(0, 20), 1'b1, cut, -1);
            end
            else if (kind < 75)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    w = $urandom;
                    h = $urandom;
                end
                else
                begin
                    w = 32'($urandom_range(1, 3));
                    h = 32'($urandom_range(1, 16));
                end
                run_image(w, h, HEADER_BYTES + $urandom_range(1, 30), 1'b1, -1, -1);
            end
            else if (kind < 90)
                run_image(w, h, $urandom_range(1, full), 1'b1, -1, -1);
            else
                run_image($urandom, $urandom, $urandom_range(1, 20), 1'b0, -1, -1);
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);

        if (sb.pending() != 0)
            $display("%0d stego bytes never came out", sb.pending());
        $display("Streamed %0d image bytes over %0d images with %0d register writes.",
                 bytes_sent, images, reg_writes);
        $display("%0d secret bytes hidden, %0d bytes after embedding, %0d bytes of short images.",
                 sb.secret_bytes_taken, sb.done_bytes, sb.short_bytes);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
